// ===== rtl/starfield_star_update_project_assert.svh =====
// ----------------------------------------------------------------------------
// starfield star update assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef STARFIELD_STAR_UPDATE_PROJECT_ASSERT_SVH
`define STARFIELD_STAR_UPDATE_PROJECT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// plain invariant checked at every edge
`define SFP_ASSERT_HOLD(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// same-cycle implication
`define SFP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define SFP_ASSERT_HOLD(lbl, expr, msg)
`define SFP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// types and constants shared by the starfield star update block
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int STAR_COUNT = 1024;
	localparam int STAR_AW    = $clog2(STAR_COUNT);
	localparam int STAR_DW    = 48;

	localparam int PIX_W      = 12;
	localparam int DIV_STAGES = PIX_W;

	localparam int FIFO_AW    = 5;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	localparam int CFG_IW     = 2;
	localparam int CFG_DW     = 16;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_STAR_SPEED    = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_FOCAL_SCALE   = 2'd3;

	localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd800;
	localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd600;
	localparam logic [15:0] RST_STAR_SPEED    = 16'd192;
	localparam logic [12:0] RST_FOCAL_SCALE   = 13'd1024;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef struct packed {
		logic               func;
		logic [9:0]         star_index;
		logic signed [15:0] load_x;
		logic signed [15:0] load_y;
		logic [15:0]        load_z;
		logic [15:0]        rand_x;
		logic [15:0]        rand_y;
	} in_t;

	typedef struct packed {
		logic [9:0]       out_index;
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic             on_screen;
		logic             wrapped;
	} out_t;

	// divider stage payload, both coordinates share the denominator
	typedef struct packed {
		logic [9:0]       idx;
		logic             wrap;
		logic [16:0]      den;
		logic             offx;
		logic             offy;
		logic [30:0]      rx;
		logic [30:0]      ry;
		logic [PIX_W-1:0] qx;
		logic [PIX_W-1:0] qy;
	} dv_t;

endpackage

// ===== rtl/sfp_ram.sv =====
// ----------------------------------------------------------------------------
// sfp_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// a read at the address being written returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/starfield_star_update_project.sv =====
// ----------------------------------------------------------------------------
// starfield_star_update_project
// star table with depth step, wrap re-draw and perspective projection
// ----------------------------------------------------------------------------
// loads give no result
// throughput: one item per cycle while not stalled, set by the star ram rmw in
//   stage 1 (one-entry write forwarding) and the 12-stage restoring divider
// input stalls while 32 step results are in flight or queued at the output
// reset clears pipeline valids, queue and credits, config to its defaults;
//   the star table has no clearing pass and is undefined until loaded
`include "starfield_star_update_project_assert.svh"

module starfield_star_update_project (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sfp_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sfp_pkg::out_t              out_data,
	input  logic                       cfg_we,
	input  logic [sfp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [sfp_pkg::CFG_DW-1:0] cfg_data
);

	import sfp_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [11:0] w_q;
	logic [11:0] h_q;
	logic [15:0] speed_q;
	logic [12:0] focal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= RST_SCREEN_WIDTH;
			h_q     <= RST_SCREEN_HEIGHT;
			speed_q <= RST_STAR_SPEED;
			focal_q <= RST_FOCAL_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  w_q     <= cfg_data[11:0];
				CFG_SCREEN_HEIGHT: h_q     <= cfg_data[11:0];
				CFG_STAR_SPEED:    speed_q <= cfg_data;
				CFG_FOCAL_SCALE:   focal_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// input accept and credit count
	// every step transaction reserves one output queue slot at accept, so
	// the pipeline never has to stop and the queue can never overflow
	// ------------------------------------------------------------------
	logic               in_acc;
	logic               in_range;
	logic               step_acc;
	logic               fifo_push;
	logic               fifo_pop;
	logic [FIFO_AW:0]   used_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;

	assign in_stall = (used_q >= (FIFO_AW+1)'(FIFO_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign in_range = (32'(in_data.star_index) < STAR_COUNT);
	assign step_acc = in_acc && in_range && (in_data.func == FUNC_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			case ({step_acc, fifo_pop})
				2'b10:   used_q <= used_q + 1'b1;
				2'b01:   used_q <= used_q - 1'b1;
				default: used_q <= used_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage 0: ram read and the wrap re-draw products from the input item
	// ------------------------------------------------------------------
	logic [STAR_DW-1:0] ram_rdata;
	logic               ram_we;
	logic [STAR_AW-1:0] ram_waddr;
	logic [STAR_DW-1:0] ram_wdata;

	sfp_ram #(
		.WIDTH(STAR_DW),
		.DEPTH(STAR_COUNT)
	) u_star_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(STAR_AW'(in_data.star_index)),
		.rdata(ram_rdata)
	);

	logic               vld_s1;
	logic               func_s1;
	logic               inr_s1;
	logic [9:0]         idx_s1;
	logic [15:0]        ldx_s1;
	logic [15:0]        ldy_s1;
	logic [15:0]        ldz_s1;
	logic [27:0]        prx_s1;
	logic [27:0]        pry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= in_data.func;
			inr_s1  <= in_range;
			idx_s1  <= in_data.star_index;
			ldx_s1  <= in_data.load_x;
			ldy_s1  <= in_data.load_y;
			ldz_s1  <= in_data.load_z;
			prx_s1  <= 28'(in_data.rand_x) * 28'(w_q);
			pry_s1  <= 28'(in_data.rand_y) * 28'(h_q);
		end
	end

	// ------------------------------------------------------------------
	// stage 1: read-modify-write of the star entry
	// ------------------------------------------------------------------
	// last write, forwarded to the item whose read met that write
	logic               wr_vld_q;
	logic [STAR_AW-1:0] wr_idx_q;
	logic [STAR_DW-1:0] wr_data_q;

	logic [STAR_DW-1:0] cur_w;
	logic [15:0]        z_old_w;
	logic               wrap_w;
	logic signed [16:0] wx_w;
	logic signed [16:0] wy_w;
	logic signed [16:0] x_new_w;
	logic signed [16:0] y_new_w;
	logic [15:0]        z_new_w;

	always_comb begin
		if (wr_vld_q && (wr_idx_q == STAR_AW'(idx_s1))) begin
			cur_w = wr_data_q;
		end else begin
			cur_w = ram_rdata;
		end
		z_old_w = cur_w[15:0];
		wrap_w  = (z_old_w <= speed_q);
		// rand*W - W/2 in q12.4, floored
		wx_w    = $signed({1'b0, prx_s1[27:12]}) - $signed({2'b00, w_q, 3'b000});
		wy_w    = $signed({1'b0, pry_s1[27:12]}) - $signed({2'b00, h_q, 3'b000});
		if (wrap_w) begin
			x_new_w = wx_w;
			y_new_w = wy_w;
			z_new_w = {w_q, 4'b0000};
		end else begin
			x_new_w = $signed({cur_w[47], cur_w[47:32]});
			y_new_w = $signed({cur_w[31], cur_w[31:16]});
			z_new_w = z_old_w - speed_q;
		end
	end

	assign ram_we    = vld_s1 && inr_s1;
	assign ram_waddr = STAR_AW'(idx_s1);
	assign ram_wdata = (func_s1 == FUNC_STEP) ?
		{x_new_w[15:0], y_new_w[15:0], z_new_w} : {ldx_s1, ldy_s1, ldz_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else begin
			wr_vld_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_idx_q  <= ram_waddr;
			wr_data_q <= ram_wdata;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: products x*F, W*z and the same for y
	// ------------------------------------------------------------------
	logic               vld_s2;
	logic [9:0]         idx_s2;
	logic               wrap_s2;
	logic signed [16:0] x_s2;
	logic signed [16:0] y_s2;
	logic [15:0]        z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && inr_s1 && (func_s1 == FUNC_STEP);
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		wrap_s2 <= wrap_w;
		x_s2    <= x_new_w;
		y_s2    <= y_new_w;
		z_s2    <= z_new_w;
	end

	logic               vld_s3;
	logic [9:0]         idx_s3;
	logic               wrap_s3;
	logic [15:0]        z_s3;
	logic signed [29:0] ax_s3;
	logic signed [29:0] ay_s3;
	logic [27:0]        bx_s3;
	logic [27:0]        by_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s3  <= idx_s2;
		wrap_s3 <= wrap_s2;
		z_s3    <= z_s2;
		ax_s3   <= $signed(30'(x_s2)) * $signed(30'({1'b0, focal_q}));
		ay_s3   <= $signed(30'(y_s2)) * $signed(30'({1'b0, focal_q}));
		bx_s3   <= 28'(w_q) * 28'(z_s2);
		by_s3   <= 28'(h_q) * 28'(z_s2);
	end

	// ------------------------------------------------------------------
	// stage 3: numerators 2*x*F + W*z over the denominator 2*z
	// ------------------------------------------------------------------
	logic               vld_s4;
	logic [9:0]         idx_s4;
	logic               wrap_s4;
	logic [15:0]        z_s4;
	logic signed [31:0] nx_s4;
	logic signed [31:0] ny_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s4  <= idx_s3;
		wrap_s4 <= wrap_s3;
		z_s4    <= z_s3;
		nx_s4   <= $signed({ax_s3[29], ax_s3, 1'b0}) + $signed({4'b0000, bx_s3});
		ny_s4   <= $signed({ay_s3[29], ay_s3, 1'b0}) + $signed({4'b0000, by_s3});
	end

	// ------------------------------------------------------------------
	// stage 4: range screening, then one quotient bit per divider stage
	// a negative numerator floors below zero, and one at or above 4096
	// denominators lands past any screen, so only 12 quotient bits remain
	// ------------------------------------------------------------------
	logic [30:0] lim_w;
	logic        zero_w;
	dv_t         dv_in_w;

	assign lim_w  = {2'b00, z_s4, 13'd0};
	assign zero_w = (z_s4 == 16'd0);

	always_comb begin
		dv_in_w.idx  = idx_s4;
		dv_in_w.wrap = wrap_s4;
		dv_in_w.den  = {z_s4, 1'b0};
		dv_in_w.offx = zero_w || nx_s4[31] || (nx_s4[30:0] >= lim_w);
		dv_in_w.offy = zero_w || ny_s4[31] || (ny_s4[30:0] >= lim_w);
		dv_in_w.rx   = nx_s4[30:0];
		dv_in_w.ry   = ny_s4[30:0];
		dv_in_w.qx   = '0;
		dv_in_w.qy   = '0;
	end

	logic [DIV_STAGES:0] dv_vld_s;
	dv_t                 dv_s  [DIV_STAGES+1];
	dv_t                 dv_nx [DIV_STAGES];

	// stage k resolves quotient bit DIV_STAGES-1-k for both coordinates
	always_comb begin
		logic [30:0] sh;
		for (int k = 0; k < DIV_STAGES; k++) begin
			dv_nx[k] = dv_s[k];
			sh       = 31'(dv_s[k].den) << (DIV_STAGES - 1 - k);
			if (dv_s[k].rx >= sh) begin
				dv_nx[k].rx                    = dv_s[k].rx - sh;
				dv_nx[k].qx[DIV_STAGES - 1 - k] = 1'b1;
			end
			if (dv_s[k].ry >= sh) begin
				dv_nx[k].ry                    = dv_s[k].ry - sh;
				dv_nx[k].qy[DIV_STAGES - 1 - k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s <= '0;
		end else begin
			dv_vld_s <= {dv_vld_s[DIV_STAGES-1:0], vld_s4};
		end
	end

	always_ff @(posedge clk) begin
		dv_s[0] <= dv_in_w;
		for (int k = 0; k < DIV_STAGES; k++) begin
			dv_s[k+1] <= dv_nx[k];
		end
	end

	// ------------------------------------------------------------------
	// final: on-screen test and output queue
	// ------------------------------------------------------------------
	dv_t  dv_last_w;
	logic on_w;
	out_t res_w;

	assign dv_last_w = dv_s[DIV_STAGES];
	assign on_w      = !dv_last_w.offx && !dv_last_w.offy &&
		(dv_last_w.qx < w_q) && (dv_last_w.qy < h_q);

	always_comb begin
		res_w.out_index = dv_last_w.idx;
		res_w.pixel_x   = on_w ? dv_last_w.qx : '0;
		res_w.pixel_y   = on_w ? dv_last_w.qy : '0;
		res_w.on_screen = on_w;
		res_w.wrapped   = dv_last_w.wrap;
	end

	out_t fifo_mem_q [FIFO_DEPTH];

	assign fifo_push = dv_vld_s[DIV_STAGES];
	assign out_valid = (cnt_q != '0);
	assign fifo_pop  = out_valid && !out_stall;
	assign out_data  = fifo_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (fifo_push) begin
			fifo_mem_q[wr_ptr_q] <= res_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fifo_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (fifo_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({fifo_push, fifo_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	logic [15:0] wz_w;
	assign wz_w = {w_q, 4'b0000};

	// queued results never outrun the reserved credits
	`SFP_ASSERT_HOLD(a_credit_cover, cnt_q <= used_q, "output queue holds more than credited")
	// a push never lands on a full queue
	`SFP_ASSERT_IMPL(a_no_overflow, fifo_push, (cnt_q < (FIFO_AW+1)'(FIFO_DEPTH)) || fifo_pop,
		"output queue overflow")
	// a wrapped star leaves with depth equal to the screen width in q12.4
	`SFP_ASSERT_IMPL(a_wrap_depth, vld_s2 && wrap_s2, z_s2 == $past(wz_w),
		"wrapped depth differs from screen width")
	// an off-screen result carries zero pixels
	`SFP_ASSERT_IMPL(a_off_zero, out_valid && !out_data.on_screen,
		(out_data.pixel_x == '0) && (out_data.pixel_y == '0), "off-screen pixel not zero")

endmodule

// ===== sim/starfield_star_update_project_tb.sv =====
// ----------------------------------------------------------------------------
// starfield_star_update_project_tb
// drives load and step transactions into the star table and checks every
// projected pixel against an in-bench prediction of depth step, wrap re-draw
// and perspective projection, across several register settings and idling mixes
// ----------------------------------------------------------------------------
module starfield_star_update_project_tb;
	import sfp_pkg::*;

	localparam int SETTLE_CYCLES = 40;      // well past the pipeline depth
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 175;
	localparam int HOLD_OFF_LEN  = 300;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		in_t               item;
		bit                typed;      // expected pixel typed into the row
		out_t              result;
		logic [CFG_IW-1:0] reg_index;
		logic [CFG_DW-1:0] reg_value;
	} stim_row_t;

	// dut connections; the inputs are all known from time zero
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	in_t               in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_t              out_data;
	logic              cfg_we    = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data  = '0;

	// predicted register copies
	logic [11:0] width_reg  = RST_SCREEN_WIDTH;
	logic [11:0] height_reg = RST_SCREEN_HEIGHT;
	logic [15:0] speed_reg  = RST_STAR_SPEED;
	logic [12:0] focal_reg  = RST_FOCAL_SCALE;

	// predicted star table
	logic signed [15:0] star_x_mem [STAR_COUNT];
	logic signed [15:0] star_y_mem [STAR_COUNT];
	logic [15:0]        star_z_mem [STAR_COUNT];
	bit                 star_loaded [STAR_COUNT];

	out_t      pixel_queue [$];   // pixels still owed by the block
	stim_row_t stim_table [$];

	int error_count       = 0;
	int cycle_count       = 0;
	int sender_idle_pct   = 0;
	int recv_stall_pct    = 0;
	int hold_off_request  = 0;
	int hold_off_left     = 0;

	starfield_star_update_project u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor division, quotient rounded toward minus infinity
	function automatic longint floor_quot(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	// star table update and projection; returns 1 when a pixel is produced
	function automatic bit project_star(input in_t it, output out_t pix);
		longint x, y, z, w, h, f, col, row;
		bit     wrap, on;
		pix  = '0;
		wrap = 1'b0;
		w    = longint'(width_reg);
		h    = longint'(height_reg);
		f    = longint'(focal_reg);
		if (it.func == FUNC_LOAD) begin
			star_x_mem[it.star_index]  = it.load_x;
			star_y_mem[it.star_index]  = it.load_y;
			star_z_mem[it.star_index]  = it.load_z;
			star_loaded[it.star_index] = 1'b1;
			return 1'b0;
		end
		x = longint'(star_x_mem[it.star_index]);
		y = longint'(star_y_mem[it.star_index]);
		z = longint'(star_z_mem[it.star_index]);
		if (z <= longint'(speed_reg)) begin
			// depth ran out: back to the far plane, position re-drawn
			wrap = 1'b1;
			z    = w * 16;
			x    = ((longint'(it.rand_x) * w) >> 12) - w * 8;
			y    = ((longint'(it.rand_y) * h) >> 12) - h * 8;
			star_x_mem[it.star_index] = x[15:0];
			star_y_mem[it.star_index] = y[15:0];
		end else begin
			z = z - longint'(speed_reg);
		end
		star_z_mem[it.star_index] = z[15:0];
		on = 1'b0;
		if (z != 0) begin
			col = floor_quot(2 * x * f + w * z, 2 * z);
			row = floor_quot(2 * y * f + h * z, 2 * z);
			on  = col >= 0 && col < w && row >= 0 && row < h;
		end
		pix.out_index = it.star_index;
		pix.pixel_x   = on ? col[11:0] : '0;
		pix.pixel_y   = on ? row[11:0] : '0;
		pix.on_screen = on;
		pix.wrapped   = wrap;
		return 1'b1;
	endfunction

	// signed coordinate: extremes, small values near center, or anything
	function automatic logic signed [15:0] random_coord();
		int pick, v;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			case ($urandom_range(0, 3))
				0:       v = -32768;
				1:       v = 32767;
				2:       v = 0;
				default: v = -1;
			endcase
		end else if (pick < 50) begin
			v = int'($urandom_range(0, 4095)) - 2048;
		end else begin
			v = $urandom;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] random_fraction();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return 16'h0000;
		else if (pick < 20)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// mostly steps on a small working set so stars walk down to the wrap,
	// loads fill the set and re-seed depths, some transactions hit any entry
	function automatic in_t random_star_item();
		in_t it;
		int  pick, nz;
		if ($urandom_range(0, 4) == 0)
			it.star_index = 10'($urandom_range(0, STAR_COUNT - 1));
		else
			it.star_index = 10'($urandom_range(0, 15));
		// never step an entry that was never loaded
		if (!star_loaded[it.star_index] || $urandom_range(0, 3) == 0)
			it.func = FUNC_LOAD;
		else
			it.func = FUNC_STEP;
		it.load_x = random_coord();
		it.load_y = random_coord();
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			it.load_z = 16'h0000;
		end else if (pick < 20) begin
			it.load_z = 16'hFFFF;
		end else if (pick < 45) begin
			// depth right around the step size, wrap boundary
			nz = int'(speed_reg) + int'($urandom_range(0, 63)) - 32;
			if (nz < 0)
				nz = 0;
			if (nz > 65535)
				nz = 65535;
			it.load_z = nz[15:0];
		end else begin
			it.load_z = 16'($urandom);
		end
		it.rand_x = random_fraction();
		it.rand_y = random_fraction();
		return it;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// append one row at the end of the stimulus table
	function automatic void append_row(input stim_row_t r);
		stim_table = {stim_table, r};
	endfunction

	function automatic void add_load(input logic [9:0] idx, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z);
		stim_row_t r;
		r.kind            = ROW_ITEM;
		r.item            = '0;
		r.item.func       = FUNC_LOAD;
		r.item.star_index = idx;
		r.item.load_x     = x;
		r.item.load_y     = y;
		r.item.load_z     = z;
		r.typed           = 1'b0;
		r.result          = '0;
		r.reg_index       = '0;
		r.reg_value       = '0;
		append_row(r);
	endfunction

	function automatic void add_step(input logic [9:0] idx, input logic [15:0] rx,
			input logic [15:0] ry, input bit typed, input int px, input int py,
			input bit on, input bit wr);
		stim_row_t r;
		r.kind             = ROW_ITEM;
		r.item             = '0;
		r.item.func        = FUNC_STEP;
		r.item.star_index  = idx;
		r.item.rand_x      = rx;
		r.item.rand_y      = ry;
		r.typed            = typed;
		r.result.out_index = idx;
		r.result.pixel_x   = 12'(px);
		r.result.pixel_y   = 12'(py);
		r.result.on_screen = on;
		r.result.wrapped   = wr;
		r.reg_index        = '0;
		r.reg_value        = '0;
		append_row(r);
	endfunction

	function automatic void add_cfg(input logic [CFG_IW-1:0] idx,
			input logic [CFG_DW-1:0] value);
		stim_row_t r;
		r.kind      = ROW_CFG;
		r.item      = '0;
		r.typed     = 1'b0;
		r.result    = '0;
		r.reg_index = idx;
		r.reg_value = value;
		append_row(r);
	endfunction

	// offer one transaction from a falling edge, hold it until taken,
	// and come back at the next falling edge
	task automatic offer(input in_t it, input bit typed, input out_t typed_res);
		out_t res;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		if (project_star(it, res)) begin
			if (typed)
				res = typed_res;
			pixel_queue = {pixel_queue, res};
		end
		@(negedge clk);
	endtask

	// sender goes quiet until every owed pixel is back, then lets the
	// pipeline empty of loads too
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pixel_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SCREEN_WIDTH:  width_reg  = value[11:0];
			CFG_SCREEN_HEIGHT: height_reg = value[11:0];
			CFG_STAR_SPEED:    speed_reg  = value[15:0];
			CFG_FOCAL_SCALE:   focal_reg  = value[12:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] s, input logic [15:0] f);
		write_reg(CFG_SCREEN_WIDTH, w);
		write_reg(CFG_SCREEN_HEIGHT, h);
		write_reg(CFG_STAR_SPEED, s);
		write_reg(CFG_FOCAL_SCALE, f);
	endtask

	// receiver: random stall, or a long hold-off counted here
	always @(negedge clk) begin
		if (hold_off_request > 0) begin
			hold_off_left    = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_off_left > 0) begin
			hold_off_left = hold_off_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// result checker, oldest owed pixel first
	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_queue.size() == 0) begin
				$display("%0t result transaction with none owed: expected nothing, actual %h",
					$time, out_data);
				error_count++;
			end else begin
				want = pixel_queue.pop_front();
				check_field("out_index", want.out_index, out_data.out_index);
				check_field("pixel_x", want.pixel_x, out_data.pixel_x);
				check_field("pixel_y", want.pixel_y, out_data.pixel_y);
				check_field("on_screen", want.on_screen, out_data.on_screen);
				check_field("wrapped", want.wrapped, out_data.wrapped);
			end
		end
	end

	// run limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : main_seq
		int phase, n;

		// directed rows at the reset register values
		add_load(10'd0, 16'd0, 16'd0, 16'd1600);
		add_step(10'd0, 16'd0, 16'd0, 1'b1, 400, 300, 1'b1, 1'b0);
		// top entry, depth zero wraps with both fractions at zero
		add_load(10'd1023, 16'h7FFF, 16'h8000, 16'd0);
		add_step(10'd1023, 16'h0000, 16'h0000, 1'b1, 0, 0, 1'b0, 1'b1);
		// depth equal to the step wraps, fractions at full scale
		add_load(10'd5, 16'hFFFF, 16'd1, 16'd192);
		add_step(10'd5, 16'hFFFF, 16'hFFFF, 1'b1, 0, 0, 1'b0, 1'b1);
		// depth one above the step: no wrap, depth 1 left
		add_load(10'd6, 16'd0, 16'd0, 16'd193);
		add_step(10'd6, 16'd0, 16'd0, 1'b1, 400, 300, 1'b1, 1'b0);
		// then a wrap with half fractions lands on the center
		add_step(10'd6, 16'h8000, 16'h8000, 1'b1, 400, 300, 1'b1, 1'b1);
		add_load(10'd7, 16'h7FFF, 16'h8000, 16'hFFFF);
		add_step(10'd7, 16'h1234, 16'h4321, 1'b0, 0, 0, 1'b0, 1'b0);
		add_load(10'd512, 16'h8000, 16'h7FFF, 16'hFFFF);
		add_step(10'd512, 16'hFFFF, 16'h0000, 1'b0, 0, 0, 1'b0, 1'b0);
		add_load(10'd341, 16'h5555, 16'hAAAA, 16'hAAAA);
		add_step(10'd341, 16'h5555, 16'hAAAA, 1'b0, 0, 0, 1'b0, 1'b0);
		// zero focal scale puts every star on the center
		add_cfg(CFG_FOCAL_SCALE, 16'd0);
		add_load(10'd9, 16'h7FFF, 16'h7FFF, 16'd1000);
		add_step(10'd9, 16'd0, 16'd0, 1'b1, 400, 300, 1'b1, 1'b0);
		// zero width: nothing is on screen, a wrap leaves zero depth
		add_cfg(CFG_SCREEN_WIDTH, 16'd0);
		add_step(10'd9, 16'd0, 16'd0, 1'b1, 0, 0, 1'b0, 1'b0);
		add_load(10'd10, 16'd100, 16'd100, 16'd0);
		add_step(10'd10, 16'h8000, 16'h8000, 1'b1, 0, 0, 1'b0, 1'b1);
		add_cfg(CFG_SCREEN_WIDTH, 16'd800);
		add_cfg(CFG_FOCAL_SCALE, 16'd1024);
		// zero stored depth wraps back to a full-size star
		add_step(10'd10, 16'h8000, 16'h8000, 1'b1, 400, 300, 1'b1, 1'b1);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_table[r]) begin
			if (stim_table[r].kind == ROW_CFG) begin
				wait_drained();
				write_reg(stim_table[r].reg_index, stim_table[r].reg_value);
			end else begin
				offer(stim_table[r].item, stim_table[r].typed, stim_table[r].result);
			end
		end

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_drained();
			case (phase)
				1: set_regs(16'd4095, 16'd4095, 16'd0, 16'd4096);      // upper extremes
				2: set_regs(16'd1, 16'd1, 16'd65535, 16'd1);           // lower extremes
				3, 7: set_regs(16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(1, 4096)));
				4: set_regs(16'd640, 16'd480, 16'd16, 16'd2048);
				5: set_regs(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));                                    // upper bits dropped
				6: set_regs(16'd801, 16'd599, 16'd1000, 16'd777);      // odd sizes
				default: ;
			endcase
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
				1: begin
					sender_idle_pct = 85;
					recv_stall_pct  = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 85;
				end
				default: begin
					sender_idle_pct = 7;
					recv_stall_pct  = 7;
				end
			endcase
			// long receiver hold-off while the sender keeps pushing: fills the
			// result queue until the input stalls
			if (phase == 4)
				hold_off_request = HOLD_OFF_LEN;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// sender pause mid-phase until the block has emptied
				if (phase == 5 && n == PHASE_ITEMS / 2)
					wait_drained();
				offer(random_star_item(), 1'b0, '0);
			end
		end

		wait_drained();
		if (error_count == 0 && pixel_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sfp_ram.sv
rtl/starfield_star_update_project.sv
sim/starfield_star_update_project_tb.sv
